// ----- rtl/rgba_alpha_weighted_union_assert.svh -----
// Assertion macros for the pixel blend block.
`ifndef RGBA_ALPHA_WEIGHTED_UNION_ASSERT_SVH
`define RGBA_ALPHA_WEIGHTED_UNION_ASSERT_SVH

`ifndef SYNTHESIS

// Check that a condition implies another in the same cycle.
`define RAWU_ASSERT_SAME(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("rawu assertion failed");

// Check that a condition implies another in the next cycle.
`define RAWU_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("rawu assertion failed");

`else

`define RAWU_ASSERT_SAME(label, clk, rst, cond, expr)
`define RAWU_ASSERT_NEXT(label, clk, rst, cond, expr)

`endif

`endif

// ----- rtl/rawu_pkg.sv -----
// Shared types, constants and the divide step of the pixel blend block.
package rawu_pkg;

   localparam int unsigned DivStages     = 4;
   localparam int unsigned StepsPerStage = 4;
   localparam logic [16:0] WGT_ONE       = 17'h10000;
   localparam logic [7:0]  CHAN_MAX      = 8'd255;

   typedef struct packed {
      logic [31:0] base_px;
      logic [23:0] over_rgb;
      logic        over_small;
      logic        zero;
      logic        bypass;
   } rawu_item_type;

   typedef struct packed {
      rawu_item_type item;
      logic [7:0]    alpha_hi;
      logic [7:0]    rem;
      logic [16:0]   quo;
   } rawu_div_type;

   typedef struct packed {
      logic [31:0]      base_px;
      logic [7:0]       alpha;
      logic             zero;
      logic             bypass;
      logic [2:0][24:0] prod_a;
      logic [2:0][24:0] prod_b;
   } rawu_prod_type;

   function automatic rawu_div_type rawu_div_step(rawu_div_type d);
      logic [8:0]   t;
      logic         ge;
      rawu_div_type r;
      r      = d;
      t      = {d.rem, 1'b0};
      ge     = t >= {1'b0, d.alpha_hi};
      r.rem  = ge ? 8'(t - {1'b0, d.alpha_hi}) : t[7:0];
      r.quo  = {d.quo[15:0], ge};
      return r;
   endfunction

endpackage

// ----- rtl/rawu_req_if.sv -----
// Input channel: base and overlay pixel words with valid/ready.
interface rawu_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_a;
   logic        a_present;
   logic [31:0] pixel_b;
   logic        b_present;

   modport source (output valid, output pixel_a, output a_present,
                   output pixel_b, output b_present, input ready);
   modport sink   (input valid, input pixel_a, input a_present,
                   input pixel_b, input b_present, output ready);
endinterface

// ----- rtl/rawu_rsp_if.sv -----
// Result channel: blended pixel word with valid/ready.
interface rawu_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pixel_out;

   modport source (output valid, output pixel_out, input ready);
   modport sink   (input valid, input pixel_out, output ready);
endinterface

// ----- rtl/rgba_alpha_weighted_union.sv -----
// Top level of the alpha-weighted RGBA8888 pixel blend.
// Takes one base/overlay pixel pair per clock while rsp ready stays high and
// returns one blended pixel per pair, in order. A pair passes through seven
// register stages before its result shows on the rsp side: one setup stage,
// four stages of the 16-bit restoring divide that forms the Q1.16 weight
// (four quotient bits per stage), one stage of weight products and one output
// stage that sums, saturates and packs. Every stage holds its word while the
// next one is full, and empty stages fill behind a stalled output, so up to
// seven pairs are in flight and throughput is one pixel per clock while rsp
// ready stays high.
`include "rgba_alpha_weighted_union_assert.svh"

module rgba_alpha_weighted_union import rawu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   rawu_req_if.sink   req_if,
   rawu_rsp_if.source rsp_if
);

   logic         prep_vld, prep_rdy;
   rawu_div_type prep_dat;
   logic         div_vld, div_rdy;
   rawu_div_type div_dat;

   rawu_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .out_valid (prep_vld),
      .out_ready (prep_rdy),
      .out_data  (prep_dat)
   );

   rawu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_vld),
      .in_ready  (prep_rdy),
      .in_data   (prep_dat),
      .out_valid (div_vld),
      .out_ready (div_rdy),
      .out_data  (div_dat)
   );

   rawu_mix u_mix (
      .clock    (clock),
      .reset    (reset),
      .in_valid (div_vld),
      .in_ready (div_rdy),
      .in_data  (div_dat),
      .rsp_if   (rsp_if)
   );

   `RAWU_ASSERT_SAME(a_full_when_blocked, clock, reset, !req_if.ready, prep_vld && div_vld && rsp_if.valid && !rsp_if.ready)
   `RAWU_ASSERT_NEXT(a_div_hold, clock, reset, div_vld && !div_rdy, div_vld && $stable(div_dat))
   `RAWU_ASSERT_SAME(a_weight_max, clock, reset, div_vld && !div_dat.item.zero && div_dat.quo[16], div_dat.quo[15:0] == 16'd0)

endmodule

// ----- rtl/rawu_prep.sv -----
// Front stage: select base, order alphas, set up the weight divide.
module rawu_prep import rawu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   rawu_req_if.sink     req_if,
   output logic         out_valid,
   input  logic         out_ready,
   output rawu_div_type out_data
);

   logic         vld_ff, vld_in;
   rawu_div_type dat_ff, dat_in;
   logic         en;
   logic [31:0]  base;
   logic [7:0]   aa, ab, alpha_lo;
   logic         eq;

   assign en           = !vld_ff || out_ready;
   assign req_if.ready = en;
   assign vld_in       = en ? req_if.valid : vld_ff;

   always_comb begin
      base  = req_if.a_present ? req_if.pixel_a : 32'd0;
      aa    = base[7:0];
      ab    = req_if.pixel_b[7:0];
      dat_in.item.base_px    = base;
      dat_in.item.over_rgb   = req_if.pixel_b[31:8];
      dat_in.item.over_small = aa > ab;
      dat_in.item.bypass     = !req_if.b_present;
      alpha_lo               = (aa > ab) ? ab : aa;
      dat_in.alpha_hi        = (aa > ab) ? aa : ab;
      dat_in.item.zero       = dat_in.alpha_hi == 8'd0;
      eq                     = alpha_lo == dat_in.alpha_hi;
      dat_in.rem             = eq ? 8'd0 : alpha_lo;
      dat_in.quo             = {16'd0, eq};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en && req_if.valid) begin
         dat_ff <= dat_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_data  = dat_ff;

endmodule

// ----- rtl/rawu_div.sv -----
// Pipelined restoring divide for the Q1.16 weight, several bits per stage.
module rawu_div import rawu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  rawu_div_type in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output rawu_div_type out_data
);

   logic         vld_ff [DivStages];
   rawu_div_type dat_ff [DivStages];
   logic         en     [DivStages];

   for (genvar g = 0; g < DivStages; g++) begin : g_stage
      logic         up_valid;
      logic         down_ready;
      logic         vld_in;
      rawu_div_type up_data;
      rawu_div_type dat_in;

      if (g == 0) begin : g_first
         assign up_valid = in_valid;
         assign up_data  = in_data;
      end else begin : g_mid
         assign up_valid = vld_ff[g-1];
         assign up_data  = dat_ff[g-1];
      end

      if (g == DivStages - 1) begin : g_last
         assign down_ready = out_ready;
      end else begin : g_inner
         assign down_ready = en[g+1];
      end

      assign en[g]  = !vld_ff[g] || down_ready;
      assign vld_in = en[g] ? up_valid : vld_ff[g];

      always_comb begin
         dat_in = up_data;
         for (int i = 0; i < StepsPerStage; i++) begin
            dat_in = rawu_div_step(dat_in);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else begin
            vld_ff[g] <= vld_in;
         end
      end

      always_ff @(posedge clock) begin
         if (en[g] && up_valid) begin
            dat_ff[g] <= dat_in;
         end
      end
   end

   assign in_ready  = en[0];
   assign out_valid = vld_ff[DivStages-1];
   assign out_data  = dat_ff[DivStages-1];

endmodule

// ----- rtl/rawu_mix.sv -----
// Back stages: weight products, then sum, saturate and pack the result word.
module rawu_mix import rawu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  rawu_div_type in_data,
   rawu_rsp_if.source   rsp_if
);

   logic          m_vld_ff, m_vld_in;
   rawu_prod_type m_dat_ff, m_dat_in;
   logic          o_vld_ff, o_vld_in;
   logic [31:0]   o_dat_ff, o_dat_in;
   logic          m_en, o_en;
   logic [16:0]   wq, wr, wa, wb;
   logic [7:0]    ca, cb;
   logic [25:0]   sum;
   logic [9:0]    s;
   logic [2:0][7:0] chn;

   assign o_en     = !o_vld_ff || rsp_if.ready;
   assign m_en     = !m_vld_ff || o_en;
   assign in_ready = m_en;
   assign m_vld_in = m_en ? in_valid : m_vld_ff;
   assign o_vld_in = o_en ? m_vld_ff : o_vld_ff;

   always_comb begin
      wq = in_data.quo;
      wr = WGT_ONE - in_data.quo;
      wa = in_data.item.over_small ? wr : wq;
      wb = in_data.item.over_small ? wq : wr;
      m_dat_in.base_px = in_data.item.base_px;
      m_dat_in.alpha   = in_data.alpha_hi;
      m_dat_in.zero    = in_data.item.zero;
      m_dat_in.bypass  = in_data.item.bypass;
      for (int c = 0; c < 3; c++) begin
         ca = in_data.item.base_px[31 - 8*c -: 8];
         cb = in_data.item.over_rgb[23 - 8*c -: 8];
         m_dat_in.prod_a[c] = {8'd0, wa} * {17'd0, ca};
         m_dat_in.prod_b[c] = {8'd0, wb} * {17'd0, cb};
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sum    = {1'b0, m_dat_ff.prod_a[c]} + {1'b0, m_dat_ff.prod_b[c]};
         s      = sum[25:16];
         chn[c] = (s > {2'b00, CHAN_MAX}) ? CHAN_MAX : s[7:0];
      end
      if (m_dat_ff.bypass) begin
         o_dat_in = m_dat_ff.base_px;
      end else if (m_dat_ff.zero) begin
         o_dat_in = 32'd0;
      end else begin
         o_dat_in = {chn[0], chn[1], chn[2], m_dat_ff.alpha};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else begin
         m_vld_ff <= m_vld_in;
         o_vld_ff <= o_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (m_en && in_valid) begin
         m_dat_ff <= m_dat_in;
      end
      if (o_en && m_vld_ff) begin
         o_dat_ff <= o_dat_in;
      end
   end

   assign rsp_if.valid     = o_vld_ff;
   assign rsp_if.pixel_out = o_dat_ff;

endmodule
